[rtl/acsi_pkg.sv]
package acsi_pkg;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBR      = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

    localparam logic [7:0] CMD_UP      = 8'h41;
    localparam logic [7:0] CMD_DOWN    = 8'h42;
    localparam logic [7:0] CMD_RIGHT   = 8'h43;
    localparam logic [7:0] CMD_LEFT    = 8'h44;
    localparam logic [7:0] CMD_POS     = 8'h48;
    localparam logic [7:0] CMD_ED      = 8'h4A;
    localparam logic [7:0] CMD_EL      = 8'h4B;
    localparam logic [7:0] CMD_SGR     = 8'h6D;
    localparam logic [7:0] CMD_DSR     = 8'h6E;
    localparam logic [7:0] CMD_SAVE    = 8'h73;
    localparam logic [7:0] CMD_RESTORE = 8'h75;

    localparam logic [15:0] SGR_RESET    = 16'd0;
    localparam logic [15:0] SGR_FG_LO    = 16'd30;
    localparam logic [15:0] SGR_FG_HI    = 16'd37;
    localparam logic [15:0] SGR_BG_LO    = 16'd40;
    localparam logic [15:0] SGR_BG_HI    = 16'd47;
    localparam logic [15:0] SGR_FG_EXT   = 16'd38;
    localparam logic [15:0] SGR_BG_EXT   = 16'd48;
    localparam logic [15:0] SGR_RGB_MODE = 16'd2;
    localparam logic [15:0] DSR_CPR      = 16'd6;
    localparam logic [15:0] ED_ALL       = 16'd2;
    localparam logic [15:0] EL_TO_END    = 16'd0;
    localparam logic [15:0] EL_FROM_HOME = 16'd1;
    localparam logic [15:0] NUM_MAX      = 16'hFFFF;

    localparam logic [1:0] ERASE_NONE   = 2'd0;
    localparam logic [1:0] ERASE_SCREEN = 2'd1;
    localparam logic [1:0] ERASE_SPAN   = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [7:0] COLS_RESET = 8'd80;

    typedef struct packed {
        logic        is_rgb;
        logic [23:0] value;
    } color_t;

    localparam color_t FG_RESET = '{is_rgb: 1'b0, value: 24'd7};
    localparam color_t BG_RESET = '{is_rgb: 1'b0, value: 24'd0};

    typedef struct packed {
        logic clr_total;
        logic clr_num;
        logic digit;
        logic push;
        logic push_if_digits;
        logic exec;
        logic ptr_clr;
        logic ptr_inc;
        logic sgr_eval;
        logic rgb_r;
        logic rgb_g;
        logic rgb_b;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_esc;
        logic is_lbr;
        logic is_digit;
        logic is_semi;
        logic is_quest;
        logic is_letter;
        logic is_sgr;
        logic sgr_end;
        logic rgb_lead;
        logic rgb_mode;
        logic out_free;
    } sts_t;

endpackage

[rtl/acsi_ctrl.sv]
module acsi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  acsi_pkg::sts_t sts,
    output acsi_pkg::cmd_t cmd
);

    localparam logic [1:0] P_NORMAL = 2'd0;
    localparam logic [1:0] P_ESC    = 2'd1;
    localparam logic [1:0] P_CSI    = 2'd2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SGR_SYNC = 3'd1;
    localparam logic [2:0] S_SGR_EVAL = 3'd2;
    localparam logic [2:0] S_RGB_CHK  = 3'd3;
    localparam logic [2:0] S_RGB_R    = 3'd4;
    localparam logic [2:0] S_RGB_G    = 3'd5;
    localparam logic [2:0] S_RGB_B    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [1:0] pstate_reg, pstate_next;
    logic [2:0] state_reg, state_next;
    logic       take;

    assign in_stall = !(state_reg == S_IDLE && sts.out_free);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        pstate_next = pstate_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load_out = 1'b1;
                    case (pstate_reg)
                        P_NORMAL:
                        begin
                            if (sts.is_esc)
                            begin
                                cmd.clr_total = 1'b1;
                                cmd.clr_num   = 1'b1;
                                pstate_next   = P_ESC;
                            end
                        end
                        P_ESC:
                        begin
                            if (sts.is_lbr)
                            begin
                                cmd.clr_num = 1'b1;
                                pstate_next = P_CSI;
                            end
                            else
                            begin
                                pstate_next = P_NORMAL;
                            end
                        end
                        P_CSI:
                        begin
                            if (sts.is_digit)
                            begin
                                cmd.digit = 1'b1;
                            end
                            else if (sts.is_semi)
                            begin
                                cmd.push    = 1'b1;
                                cmd.clr_num = 1'b1;
                            end
                            else if (sts.is_quest)
                            begin
                                pstate_next = P_CSI;
                            end
                            else if (sts.is_letter)
                            begin
                                cmd.push_if_digits = 1'b1;
                                cmd.clr_num        = 1'b1;
                                cmd.exec           = 1'b1;
                                pstate_next        = P_NORMAL;
                                if (sts.is_sgr)
                                begin
                                    cmd.load_out = 1'b0;
                                    cmd.ptr_clr  = 1'b1;
                                    state_next   = S_SGR_SYNC;
                                end
                            end
                            else
                            begin
                                pstate_next = P_NORMAL;
                            end
                        end
                        default:
                        begin
                            pstate_next = P_NORMAL;
                        end
                    endcase
                end
            end
            S_SGR_SYNC:
            begin
                cmd.ptr_clr = 1'b1;
                state_next  = S_SGR_EVAL;
            end
            S_SGR_EVAL:
            begin
                if (sts.sgr_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sgr_eval = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                    if (sts.rgb_lead)
                    begin
                        state_next = S_RGB_CHK;
                    end
                end
            end
            S_RGB_CHK:
            begin
                if (sts.rgb_mode)
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_RGB_R;
                end
                else
                begin
                    state_next = S_SGR_EVAL;
                end
            end
            S_RGB_R:
            begin
                cmd.rgb_r   = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_RGB_G;
            end
            S_RGB_G:
            begin
                cmd.rgb_g   = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_RGB_B;
            end
            S_RGB_B:
            begin
                cmd.rgb_b   = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_SGR_EVAL;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pstate_reg <= P_NORMAL;
        end
        else
        begin
            state_reg  <= state_next;
            pstate_reg <= pstate_next;
        end
    end

`ifndef SYNTHESIS
    a_sgr_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pstate_reg == P_CSI && sts.is_letter && sts.is_sgr)
        |=> (state_reg == S_SGR_SYNC))
        else $error("sgr letter did not start the parameter walk");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while the output register is held");

    a_rgb_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RGB_R) |-> ($past(state_reg) == S_RGB_CHK))
        else $error("rgb red fetch without a mode check");
`endif

endmodule

[rtl/acsi_dp.sv]
module acsi_dp #(
    parameter int MAX_PARAMS = 16,
    parameter int MAX_DIGITS = 15
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     byte_in,
    input  logic           cfg_valid,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           out_stall,
    input  acsi_pkg::cmd_t cmd,
    output acsi_pkg::sts_t sts,
    output logic           out_valid,
    output logic [7:0]     cursor_row,
    output logic [7:0]     cursor_col,
    output logic           fg_is_rgb,
    output logic [23:0]    fg_value,
    output logic           bg_is_rgb,
    output logic [23:0]    bg_value,
    output logic [1:0]     erase_kind,
    output logic [7:0]     erase_row,
    output logic [7:0]     erase_col,
    output logic [7:0]     erase_width,
    output logic           report_valid
);

    localparam int TW = $clog2(MAX_PARAMS + 1);
    localparam int IW = $clog2(MAX_PARAMS);
    localparam int DW = $clog2(MAX_DIGITS + 1);

    logic [DW-1:0] digits_reg, digits_next;
    logic [15:0]   acc_reg, acc_next;
    logic [TW-1:0] total_reg, total_next, ptr_reg, ptr_next, total_eff;
    logic [15:0]   p0_reg, p0_next, p1_reg, p1_next, p0_eff, p1_eff;
    logic [15:0]   pdata_reg;
    logic [15:0]   mem [MAX_PARAMS];
    logic [7:0]    rows_reg, cols_reg;
    logic [7:0]    row_reg, row_next, col_reg, col_next;
    logic [7:0]    srow_reg, srow_next, scol_reg, scol_next;
    acsi_pkg::color_t fg_reg, fg_next, bg_reg, bg_next;
    logic          fg_sel_reg, fg_sel_next;
    logic [7:0]    red_reg, red_next, green_reg, green_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    o_row_reg, o_col_reg, o_erow_reg, o_ecol_reg, o_ewidth_reg;
    acsi_pkg::color_t o_fg_reg, o_bg_reg;
    logic [1:0]    o_kind_reg;
    logic          o_rep_reg;

    logic          do_push, has0, has1;
    logic [19:0]   acc_sum;
    logic [15:0]   n, hr, hc, hr_m1, hc_m1, mode;
    logic [7:0]    rlim, clim, to_end, upto_cur;
    logic [16:0]   row_sum, col_sum;
    logic [1:0]    er_kind;
    logic [7:0]    er_row, er_col, er_width;
    logic          rep;

    assign sts.is_esc    = byte_in == acsi_pkg::CH_ESC;
    assign sts.is_lbr    = byte_in == acsi_pkg::CH_LBR;
    assign sts.is_digit  = byte_in >= acsi_pkg::CH_ZERO && byte_in <= acsi_pkg::CH_NINE;
    assign sts.is_semi   = byte_in == acsi_pkg::CH_SEMI;
    assign sts.is_quest  = byte_in == acsi_pkg::CH_QUEST;
    assign sts.is_letter = (byte_in >= acsi_pkg::CH_UPPER_A && byte_in <= acsi_pkg::CH_UPPER_Z)
                        || (byte_in >= acsi_pkg::CH_LOWER_A && byte_in <= acsi_pkg::CH_LOWER_Z);
    assign sts.is_sgr    = byte_in == acsi_pkg::CMD_SGR;
    assign sts.sgr_end   = ptr_reg >= total_reg;
    assign sts.rgb_lead  = (pdata_reg == acsi_pkg::SGR_FG_EXT || pdata_reg == acsi_pkg::SGR_BG_EXT)
                        && ((TW+1)'(ptr_reg) + (TW+1)'(4) < (TW+1)'(total_reg));
    assign sts.rgb_mode  = pdata_reg == acsi_pkg::SGR_RGB_MODE;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // parameter collection
    assign do_push = (cmd.push || (cmd.push_if_digits && digits_reg != '0))
                  && total_reg < TW'(MAX_PARAMS);
    assign acc_sum = 20'(acc_reg) * 20'd10 + 20'(byte_in[3:0]);

    always_comb
    begin
        digits_next = digits_reg;
        acc_next    = acc_reg;
        if (cmd.clr_num)
        begin
            digits_next = '0;
            acc_next    = '0;
        end
        else if (cmd.digit && digits_reg < DW'(MAX_DIGITS))
        begin
            digits_next = digits_reg + DW'(1);
            acc_next    = (acc_sum > 20'(acsi_pkg::NUM_MAX)) ? acsi_pkg::NUM_MAX
                                                            : acc_sum[15:0];
        end
        total_next = total_reg;
        if (cmd.clr_total)
            total_next = '0;
        else if (do_push)
            total_next = total_reg + TW'(1);
        p0_next = (do_push && total_reg == '0) ? acc_reg : p0_reg;
        p1_next = (do_push && total_reg == TW'(1)) ? acc_reg : p1_reg;
        if (cmd.ptr_clr)
            ptr_next = '0;
        else if (cmd.ptr_inc)
            ptr_next = ptr_reg + TW'(1);
        else
            ptr_next = ptr_reg;
    end

    assign total_eff = total_reg + TW'(do_push);
    assign p0_eff    = p0_next;
    assign p1_eff    = p1_next;
    assign has0      = total_eff != '0;
    assign has1      = total_eff > TW'(1);

    // command execution
    assign rlim     = (rows_reg == 8'd0) ? 8'd0 : rows_reg - 8'd1;
    assign clim     = (cols_reg == 8'd0) ? 8'd0 : cols_reg - 8'd1;
    assign n        = has0 ? p0_eff : 16'd1;
    assign hr       = has0 ? p0_eff : 16'd1;
    assign hc       = has1 ? p1_eff : 16'd1;
    assign hr_m1    = (hr == 16'd0) ? 16'd0 : hr - 16'd1;
    assign hc_m1    = (hc == 16'd0) ? 16'd0 : hc - 16'd1;
    assign mode     = has0 ? p0_eff : 16'd0;
    assign row_sum  = 17'(row_reg) + 17'(n);
    assign col_sum  = 17'(col_reg) + 17'(n);
    assign to_end   = (cols_reg > col_reg) ? cols_reg - col_reg : 8'd0;
    assign upto_cur = (col_reg == 8'hFF) ? 8'hFF : col_reg + 8'd1;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        er_kind   = acsi_pkg::ERASE_NONE;
        er_row    = 8'd0;
        er_col    = 8'd0;
        er_width  = 8'd0;
        rep       = 1'b0;
        if (cmd.exec)
        begin
            case (byte_in)
                acsi_pkg::CMD_UP:
                    row_next = (16'(row_reg) > n) ? row_reg - n[7:0] : 8'd0;
                acsi_pkg::CMD_DOWN:
                    row_next = (row_sum > 17'(rlim)) ? rlim : row_sum[7:0];
                acsi_pkg::CMD_RIGHT:
                    col_next = (col_sum > 17'(clim)) ? clim : col_sum[7:0];
                acsi_pkg::CMD_LEFT:
                    col_next = (16'(col_reg) > n) ? col_reg - n[7:0] : 8'd0;
                acsi_pkg::CMD_POS:
                begin
                    row_next = (hr_m1 > 16'(rlim)) ? rlim : hr_m1[7:0];
                    col_next = (hc_m1 > 16'(clim)) ? clim : hc_m1[7:0];
                end
                acsi_pkg::CMD_ED:
                begin
                    if (mode == acsi_pkg::ED_ALL)
                    begin
                        er_kind  = acsi_pkg::ERASE_SCREEN;
                        row_next = 8'd0;
                        col_next = 8'd0;
                    end
                    else
                    begin
                        er_kind  = acsi_pkg::ERASE_SPAN;
                        er_row   = row_reg;
                        er_col   = col_reg;
                        er_width = to_end;
                    end
                end
                acsi_pkg::CMD_EL:
                begin
                    er_kind = acsi_pkg::ERASE_SPAN;
                    er_row  = row_reg;
                    if (mode == acsi_pkg::EL_TO_END)
                    begin
                        er_col   = col_reg;
                        er_width = to_end;
                    end
                    else if (mode == acsi_pkg::EL_FROM_HOME)
                    begin
                        er_width = upto_cur;
                    end
                    else
                    begin
                        er_width = cols_reg;
                    end
                end
                acsi_pkg::CMD_SAVE:
                begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                end
                acsi_pkg::CMD_RESTORE:
                begin
                    row_next = srow_reg;
                    col_next = scol_reg;
                end
                acsi_pkg::CMD_DSR:
                    rep = has0 && p0_eff == acsi_pkg::DSR_CPR;
                default:
                    rep = 1'b0;
            endcase
        end
    end

    // sgr walk
    always_comb
    begin
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        fg_sel_next = fg_sel_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        if (cmd.sgr_eval)
        begin
            fg_sel_next = pdata_reg == acsi_pkg::SGR_FG_EXT;
            if (pdata_reg == acsi_pkg::SGR_RESET)
            begin
                fg_next = acsi_pkg::FG_RESET;
                bg_next = acsi_pkg::BG_RESET;
            end
            else if (pdata_reg >= acsi_pkg::SGR_FG_LO && pdata_reg <= acsi_pkg::SGR_FG_HI)
            begin
                fg_next = '{is_rgb: 1'b0, value: 24'(pdata_reg - acsi_pkg::SGR_FG_LO)};
            end
            else if (pdata_reg >= acsi_pkg::SGR_BG_LO && pdata_reg <= acsi_pkg::SGR_BG_HI)
            begin
                bg_next = '{is_rgb: 1'b0, value: 24'(pdata_reg - acsi_pkg::SGR_BG_LO)};
            end
        end
        if (cmd.rgb_r)
            red_next = pdata_reg[7:0];
        if (cmd.rgb_g)
            green_next = pdata_reg[7:0];
        if (cmd.rgb_b)
        begin
            if (fg_sel_reg)
                fg_next = '{is_rgb: 1'b1, value: {red_reg, green_reg, pdata_reg[7:0]}};
            else
                bg_next = '{is_rgb: 1'b1, value: {red_reg, green_reg, pdata_reg[7:0]}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[total_reg[IW-1:0]] <= acc_reg;
        pdata_reg <= mem[ptr_next[IW-1:0]];
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg    <= '0;
            acc_reg       <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            rows_reg      <= acsi_pkg::ROWS_RESET;
            cols_reg      <= acsi_pkg::COLS_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            srow_reg      <= '0;
            scol_reg      <= '0;
            fg_reg        <= acsi_pkg::FG_RESET;
            bg_reg        <= acsi_pkg::BG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            digits_reg    <= digits_next;
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_index == acsi_pkg::CFG_ROWS)
                rows_reg <= cfg_data;
            if (cfg_valid && cfg_index == acsi_pkg::CFG_COLS)
                cols_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        fg_sel_reg <= fg_sel_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        if (cmd.load_out)
        begin
            o_row_reg    <= row_next;
            o_col_reg    <= col_next;
            o_fg_reg     <= fg_next;
            o_bg_reg     <= bg_next;
            o_kind_reg   <= er_kind;
            o_erow_reg   <= er_row;
            o_ecol_reg   <= er_col;
            o_ewidth_reg <= er_width;
            o_rep_reg    <= rep;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_row   = o_row_reg;
    assign cursor_col   = o_col_reg;
    assign fg_is_rgb    = o_fg_reg.is_rgb;
    assign fg_value     = o_fg_reg.value;
    assign bg_is_rgb    = o_bg_reg.is_rgb;
    assign bg_value     = o_bg_reg.value;
    assign erase_kind   = o_kind_reg;
    assign erase_row    = o_erow_reg;
    assign erase_col    = o_ecol_reg;
    assign erase_width  = o_ewidth_reg;
    assign report_valid = o_rep_reg;

`ifndef SYNTHESIS
    a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sgr_eval |-> (ptr_reg < total_reg))
        else $error("sgr evaluated past the stored parameters");

    a_rgb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rgb_b |-> (ptr_reg < total_reg))
        else $error("rgb blue taken past the stored parameters");

    a_screen_erase_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_kind_reg == acsi_pkg::ERASE_SCREEN)
        |-> (o_row_reg == 8'd0 && o_col_reg == 8'd0))
        else $error("screen erase left the cursor away from home");
`endif

endmodule

[rtl/ansi_csi_terminal_parser.sv]
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    byte_in
// out      output     out_valid / out_stall  cursor, colours, erase span, report_valid
// cfg      input      cfg_valid / cfg_ready  cfg_index (0 rows, 1 cols), cfg_data
//
// An ordinary byte is taken and its result loaded into the output register in the same cycle.
// An 'm' final walks the parameter store, one read a cycle, in S_SGR_EVAL; a 38 or 48 with four
// more parameters goes to S_RGB_CHK, then S_RGB_R/G/B if the next one is 2, else back to S_SGR_EVAL.
// rst_n clears the parser, cursor and colours; rows 25, cols 80.
// in_stall is high while the walk runs or while a result is held by out_stall.
module ansi_csi_terminal_parser #(
    parameter int MAX_PARAMS = 16,
    parameter int MAX_DIGITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cursor_row,
    output logic [7:0]  cursor_col,
    output logic        fg_is_rgb,
    output logic [23:0] fg_value,
    output logic        bg_is_rgb,
    output logic [23:0] bg_value,
    output logic [1:0]  erase_kind,
    output logic [7:0]  erase_row,
    output logic [7:0]  erase_col,
    output logic [7:0]  erase_width,
    output logic        report_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    acsi_pkg::cmd_t cmd;
    acsi_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    acsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    acsi_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_in      (byte_in),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .fg_is_rgb    (fg_is_rgb),
        .fg_value     (fg_value),
        .bg_is_rgb    (bg_is_rgb),
        .bg_value     (bg_value),
        .erase_kind   (erase_kind),
        .erase_row    (erase_row),
        .erase_col    (erase_col),
        .erase_width  (erase_width),
        .report_valid (report_valid)
    );

endmodule

[bench/ansi_csi_terminal_parser_tb.sv]
`timescale 1ns / 1ps

module ansi_csi_terminal_parser_tb;

    localparam int unsigned N_PARAMS    = 16;
    localparam int unsigned N_DIGITS    = 15;
    localparam int          SETTLE      = 48;
    localparam int          QUIET_LIMIT = 3000;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 210;

    typedef enum logic [1:0] {PS_NORMAL, PS_ESC, PS_CSI} parse_mode_t;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic        fg_rgb;
        logic [23:0] fg;
        logic        bg_rgb;
        logic [23:0] bg;
        logic [1:0]  kind;
        logic [7:0]  er_row;
        logic [7:0]  er_col;
        logic [7:0]  er_width;
        logic        report;
    } result_t;

    typedef struct {
        bit         csi;
        string      body;
        logic [7:0] last;
        bit         pinned;
        result_t    want;
    } dir_row_t;

    localparam result_t RES_HOME   = '{fg: 24'd7, default: '0};
    localparam result_t RES_SCREEN = '{fg: 24'd7, kind: acsi_pkg::ERASE_SCREEN, default: '0};
    localparam result_t RES_CORNER = '{row: 8'd24, col: 8'd79, fg: 24'd7, default: '0};
    localparam result_t RES_REPORT = '{row: 8'd24, col: 8'd79, fg: 24'd7, report: 1'b1,
                                       default: '0};

    localparam logic [7:0] FINALS [14] = '{acsi_pkg::CMD_UP, acsi_pkg::CMD_DOWN,
                                           acsi_pkg::CMD_RIGHT, acsi_pkg::CMD_LEFT,
                                           acsi_pkg::CMD_POS, acsi_pkg::CMD_ED,
                                           acsi_pkg::CMD_EL, acsi_pkg::CMD_SGR,
                                           acsi_pkg::CMD_SGR, acsi_pkg::CMD_DSR,
                                           acsi_pkg::CMD_SAVE, acsi_pkg::CMD_RESTORE,
                                           acsi_pkg::CH_LOWER_Z, acsi_pkg::CH_UPPER_Z};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic        fg_is_rgb;
    logic [23:0] fg_value;
    logic        bg_is_rgb;
    logic [23:0] bg_value;
    logic [1:0]  erase_kind;
    logic [7:0]  erase_row;
    logic [7:0]  erase_col;
    logic [7:0]  erase_width;
    logic        report_valid;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    ansi_csi_terminal_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .fg_is_rgb    (fg_is_rgb),
        .fg_value     (fg_value),
        .bg_is_rgb    (bg_is_rgb),
        .bg_value     (bg_value),
        .erase_kind   (erase_kind),
        .erase_row    (erase_row),
        .erase_col    (erase_col),
        .erase_width  (erase_width),
        .report_valid (report_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // terminal state as the block should hold it
    parse_mode_t      pmode;
    logic [3:0]       ndig;
    logic [15:0]      acc;
    logic [4:0]       nparam;
    logic [15:0]      pstore [N_PARAMS];
    logic [7:0]       crow, ccol, srow, scol;
    logic [7:0]       rows_cfg, cols_cfg;
    acsi_pkg::color_t fg_c, bg_c;

    result_t     pending_results [$];
    result_t     seen, want_r;
    logic [7:0]  seq_bytes [$];
    int          miss_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    int unsigned stall_ctr = 0;

    dir_row_t dir_tab [$] = '{
        '{1'b0, "", 8'h00, 1'b1, RES_HOME},
        '{1'b0, "", 8'hFF, 1'b1, RES_HOME},
        '{1'b1, "2", acsi_pkg::CMD_ED, 1'b1, RES_SCREEN},
        '{1'b1, "99999;99", acsi_pkg::CMD_POS, 1'b1, RES_CORNER},
        '{1'b1, "6", acsi_pkg::CMD_DSR, 1'b1, RES_REPORT},
        '{1'b1, "?5", acsi_pkg::CMD_UP, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_LEFT, 1'b0, '0},
        '{1'b1, "0", acsi_pkg::CMD_RIGHT, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_SAVE, 1'b0, '0},
        '{1'b1, "300", acsi_pkg::CMD_DOWN, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_RESTORE, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_EL, 1'b0, '0},
        '{1'b1, "1", acsi_pkg::CMD_EL, 1'b0, '0},
        '{1'b1, "2", acsi_pkg::CMD_EL, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_ED, 1'b0, '0},
        '{1'b1, "31;42;38;2;300;1;255;99", acsi_pkg::CMD_SGR, 1'b0, '0},
        '{1'b1, "48;5", acsi_pkg::CMD_SGR, 1'b0, '0},
        '{1'b1, "48;2;1;2", acsi_pkg::CMD_SGR, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_SGR, 1'b0, '0},
        '{1'b1, "0000000000000007", acsi_pkg::CMD_UP, 1'b0, '0},
        '{1'b1, "33;;;;;;;;;;;;;;;;44", acsi_pkg::CMD_SGR, 1'b0, '0},
        '{1'b1, "5", 8'h21, 1'b0, '0},
        '{1'b0, "", acsi_pkg::CH_ESC, 1'b0, '0},
        '{1'b0, "", acsi_pkg::CH_ESC, 1'b0, '0},
        '{1'b0, "", acsi_pkg::CH_LBR, 1'b0, '0},
        '{1'b1, "3", acsi_pkg::CH_LOWER_Z, 1'b0, '0},
        '{1'b1, "5", acsi_pkg::CMD_DSR, 1'b0, '0},
        '{1'b1, "", acsi_pkg::CMD_POS, 1'b0, '0},
        '{1'b1, "1", acsi_pkg::CMD_EL, 1'b0, '0}
    };

    function automatic void store_param(input logic [15:0] v);
        if (nparam < N_PARAMS)
        begin
            pstore[nparam] = v;
            nparam++;
        end
    endfunction

    function automatic int unsigned param_or(input int unsigned idx, input int unsigned dflt);
        return (idx < nparam) ? pstore[idx] : dflt;
    endfunction

    function automatic result_t step_terminal(input logic [7:0] c);
        result_t     r;
        int unsigned rlim, clim, n, a, b, i;
        logic [15:0] p;
        r = '0;
        rlim = (rows_cfg == 0) ? 0 : rows_cfg - 1;
        clim = (cols_cfg == 0) ? 0 : cols_cfg - 1;
        case (pmode)
            PS_NORMAL:
                if (c == acsi_pkg::CH_ESC)
                begin
                    pmode = PS_ESC;
                    ndig = '0;
                    acc = '0;
                    nparam = '0;
                end
            PS_ESC:
                if (c == acsi_pkg::CH_LBR)
                begin
                    pmode = PS_CSI;
                    ndig = '0;
                    acc = '0;
                end
                else
                    pmode = PS_NORMAL;
            default:
                if (c >= acsi_pkg::CH_ZERO && c <= acsi_pkg::CH_NINE)
                begin
                    if (ndig < N_DIGITS)
                    begin
                        ndig++;
                        a = 32'(acc) * 10 + 32'(c - acsi_pkg::CH_ZERO);
                        acc = (a > 65535) ? acsi_pkg::NUM_MAX : 16'(a);
                    end
                end
                else if (c == acsi_pkg::CH_SEMI)
                begin
                    store_param(acc);
                    ndig = '0;
                    acc = '0;
                end
                else if (c == acsi_pkg::CH_QUEST)
                begin
                end
                else if ((c >= acsi_pkg::CH_UPPER_A && c <= acsi_pkg::CH_UPPER_Z) ||
                         (c >= acsi_pkg::CH_LOWER_A && c <= acsi_pkg::CH_LOWER_Z))
                begin
                    if (ndig != 0)
                        store_param(acc);
                    ndig = '0;
                    acc = '0;
                    n = param_or(0, 1);
                    case (c)
                        acsi_pkg::CMD_UP:
                            crow = (crow > n) ? 8'(crow - n) : 8'd0;
                        acsi_pkg::CMD_DOWN:
                        begin
                            a = crow + n;
                            crow = 8'((a < rlim) ? a : rlim);
                        end
                        acsi_pkg::CMD_RIGHT:
                        begin
                            a = ccol + n;
                            ccol = 8'((a < clim) ? a : clim);
                        end
                        acsi_pkg::CMD_LEFT:
                            ccol = (ccol > n) ? 8'(ccol - n) : 8'd0;
                        acsi_pkg::CMD_POS:
                        begin
                            a = param_or(0, 1);
                            b = param_or(1, 1);
                            a = (a == 0) ? 0 : a - 1;
                            b = (b == 0) ? 0 : b - 1;
                            crow = 8'((a < rlim) ? a : rlim);
                            ccol = 8'((b < clim) ? b : clim);
                        end
                        acsi_pkg::CMD_ED:
                            if (param_or(0, 0) == acsi_pkg::ED_ALL)
                            begin
                                r.kind = acsi_pkg::ERASE_SCREEN;
                                crow = '0;
                                ccol = '0;
                            end
                            else
                            begin
                                r.kind = acsi_pkg::ERASE_SPAN;
                                r.er_row = crow;
                                r.er_col = ccol;
                                r.er_width = (cols_cfg > ccol) ? cols_cfg - ccol : 8'd0;
                            end
                        acsi_pkg::CMD_EL:
                        begin
                            a = param_or(0, 0);
                            r.kind = acsi_pkg::ERASE_SPAN;
                            r.er_row = crow;
                            if (a == acsi_pkg::EL_TO_END)
                            begin
                                r.er_col = ccol;
                                r.er_width = (cols_cfg > ccol) ? cols_cfg - ccol : 8'd0;
                            end
                            else if (a == acsi_pkg::EL_FROM_HOME)
                                r.er_width = (ccol == 8'd255) ? 8'd255 : ccol + 8'd1;
                            else
                                r.er_width = cols_cfg;
                        end
                        acsi_pkg::CMD_SGR:
                        begin
                            i = 0;
                            while (i < nparam)
                            begin
                                p = pstore[i];
                                if (p == acsi_pkg::SGR_RESET)
                                begin
                                    fg_c = acsi_pkg::FG_RESET;
                                    bg_c = acsi_pkg::BG_RESET;
                                end
                                else if (p >= acsi_pkg::SGR_FG_LO && p <= acsi_pkg::SGR_FG_HI)
                                    fg_c = '{1'b0, 24'(p - acsi_pkg::SGR_FG_LO)};
                                else if (p >= acsi_pkg::SGR_BG_LO && p <= acsi_pkg::SGR_BG_HI)
                                    bg_c = '{1'b0, 24'(p - acsi_pkg::SGR_BG_LO)};
                                else if ((p == acsi_pkg::SGR_FG_EXT ||
                                          p == acsi_pkg::SGR_BG_EXT) &&
                                         i + 4 < nparam &&
                                         pstore[i + 1] == acsi_pkg::SGR_RGB_MODE)
                                begin
                                    if (p == acsi_pkg::SGR_FG_EXT)
                                        fg_c = '{1'b1, {pstore[i + 2][7:0], pstore[i + 3][7:0],
                                                        pstore[i + 4][7:0]}};
                                    else
                                        bg_c = '{1'b1, {pstore[i + 2][7:0], pstore[i + 3][7:0],
                                                        pstore[i + 4][7:0]}};
                                    i += 4;
                                end
                                i++;
                            end
                        end
                        acsi_pkg::CMD_SAVE:
                        begin
                            srow = crow;
                            scol = ccol;
                        end
                        acsi_pkg::CMD_RESTORE:
                        begin
                            crow = srow;
                            ccol = scol;
                        end
                        acsi_pkg::CMD_DSR:
                            if (nparam != 0 && pstore[0] == acsi_pkg::DSR_CPR)
                                r.report = 1'b1;
                        default:
                        begin
                        end
                    endcase
                    pmode = PS_NORMAL;
                end
                else
                    pmode = PS_NORMAL;
        endcase
        r.row = crow;
        r.col = ccol;
        r.fg_rgb = fg_c.is_rgb;
        r.fg = fg_c.value;
        r.bg_rgb = bg_c.is_rgb;
        r.bg = bg_c.value;
        return r;
    endfunction

    function automatic int unsigned pick_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 65535);
            2: return $urandom_range(200, 300);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    function automatic string num_text(input int unsigned v);
        case ($urandom_range(0, 15))
            0: return "";
            1: return {"00", $sformatf("%0d", v)};
            2: return $sformatf("%0d%0d", $urandom, $urandom);
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic int unsigned colour_byte();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(256, 65535) : $urandom_range(0, 255);
    endfunction

    function automatic string sgr_text();
        string       t, e;
        int unsigned k, np, ext;
        np = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
        t = "";
        for (k = 0; k < np; k++)
        begin
            ext = $urandom_range(0, 1) ? acsi_pkg::SGR_FG_EXT : acsi_pkg::SGR_BG_EXT;
            case ($urandom_range(0, 9))
                0: e = "0";
                1, 2: e = $sformatf("%0d", acsi_pkg::SGR_FG_LO + $urandom_range(0, 7));
                3, 4: e = $sformatf("%0d", acsi_pkg::SGR_BG_LO + $urandom_range(0, 7));
                5, 6: e = $sformatf("%0d;%0d;%0d;%0d;%0d", ext, acsi_pkg::SGR_RGB_MODE,
                                    colour_byte(), colour_byte(), colour_byte());
                7: e = $sformatf("%0d;%0d", ext, $urandom_range(0, 3));
                8: e = num_text($urandom_range(0, 99));
                default: e = "";
            endcase
            t = (k == 0) ? e : {t, ";", e};
        end
        return t;
    endfunction

    task automatic build_csi(input bit broken);
        logic [7:0] fin;
        string      t;
        int         k;
        fin = FINALS[$urandom_range(0, 13)];
        t = ($urandom_range(0, 7) == 0) ? "?" : "";
        case (fin)
            acsi_pkg::CMD_SGR:
                t = {t, sgr_text()};
            acsi_pkg::CMD_POS:
                case ($urandom_range(0, 3))
                    0: ;
                    1: t = {t, num_text(pick_count())};
                    default: t = {t, num_text(pick_count()), ";", num_text(pick_count())};
                endcase
            acsi_pkg::CMD_ED, acsi_pkg::CMD_EL:
                if ($urandom_range(0, 3) != 0)
                    t = {t, num_text($urandom_range(0, 3))};
            acsi_pkg::CMD_DSR:
                t = {t, num_text(($urandom_range(0, 3) != 0) ? acsi_pkg::DSR_CPR
                                                              : $urandom_range(0, 9))};
            acsi_pkg::CMD_SAVE, acsi_pkg::CMD_RESTORE:
                ;
            default:
                if ($urandom_range(0, 4) != 0)
                    t = {t, num_text(pick_count())};
        endcase
        if (broken)
            fin = 8'($urandom_range(0, 255));
        seq_bytes.delete();
        seq_bytes.push_back(acsi_pkg::CH_ESC);
        seq_bytes.push_back(acsi_pkg::CH_LBR);
        for (k = 0; k < t.len(); k++)
            seq_bytes.push_back(t[k]);
        seq_bytes.push_back(fin);
    endtask

    // one item to the block; bursts and gaps are decided after each acceptance
    task automatic feed(input logic [7:0] b, input bit pinned = 1'b0, input result_t want = '0);
        result_t r;
        in_valid <= 1'b1;
        byte_in <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = step_terminal(b);
        pending_results.push_back(pinned ? want : r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(13, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            case ($urandom_range(0, 3))
                0: burst_left = 0;
                1, 2: burst_left = $urandom_range(1, 8);
                default: burst_left = $urandom_range(30, 80);
            endcase
        end
    endtask

    task automatic hold_until_empty();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_size(input logic [7:0] rows, input logic [7:0] cols);
        int k;
        cfg_valid <= 1'b1;
        for (k = 0; k < 2; k++)
        begin
            cfg_index <= (k == 0) ? acsi_pkg::CFG_ROWS : acsi_pkg::CFG_COLS;
            cfg_data <= (k == 0) ? rows : cols;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (k == 0)
                rows_cfg = rows;
            else
                cols_cfg = cols;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic note_miss(input string what, input logic [23:0] exp_v, input logic [23:0] got_v);
        miss_count++;
        if (miss_count <= 10)
            $display("%0t %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{cursor_row, cursor_col, fg_is_rgb, fg_value, bg_is_rgb, bg_value,
                     erase_kind, erase_row, erase_col, erase_width, report_valid};
            if (pending_results.size() == 0)
                note_miss("result with no item pending, cursor_row", 24'd0, seen.row);
            else
            begin
                want_r = pending_results.pop_front();
                if (want_r.row !== seen.row) note_miss("cursor_row", want_r.row, seen.row);
                if (want_r.col !== seen.col) note_miss("cursor_col", want_r.col, seen.col);
                if (want_r.fg_rgb !== seen.fg_rgb)
                    note_miss("fg_is_rgb", want_r.fg_rgb, seen.fg_rgb);
                if (want_r.fg !== seen.fg) note_miss("fg_value", want_r.fg, seen.fg);
                if (want_r.bg_rgb !== seen.bg_rgb)
                    note_miss("bg_is_rgb", want_r.bg_rgb, seen.bg_rgb);
                if (want_r.bg !== seen.bg) note_miss("bg_value", want_r.bg, seen.bg);
                if (want_r.kind !== seen.kind) note_miss("erase_kind", want_r.kind, seen.kind);
                if (want_r.er_row !== seen.er_row)
                    note_miss("erase_row", want_r.er_row, seen.er_row);
                if (want_r.er_col !== seen.er_col)
                    note_miss("erase_col", want_r.er_col, seen.er_col);
                if (want_r.er_width !== seen.er_width)
                    note_miss("erase_width", want_r.er_width, seen.er_width);
                if (want_r.report !== seen.report)
                    note_miss("report_valid", want_r.report, seen.report);
            end
        end
    end

    // receiver back-pressure in one of four modes, chosen anew whenever stall_left runs out
    always @(posedge clk)
    begin
        stall_ctr <= stall_ctr + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_ctr[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int          r, k, ph, pick;
        int unsigned counted;
        logic [7:0]  rows_next, cols_next;

        pmode = PS_NORMAL;
        ndig = '0;
        acc = '0;
        nparam = '0;
        for (k = 0; k < N_PARAMS; k++)
            pstore[k] = '0;
        crow = '0;
        ccol = '0;
        srow = '0;
        scol = '0;
        rows_cfg = acsi_pkg::ROWS_RESET;
        cols_cfg = acsi_pkg::COLS_RESET;
        fg_c = acsi_pkg::FG_RESET;
        bg_c = acsi_pkg::BG_RESET;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        byte_in <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= acsi_pkg::CFG_ROWS;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < dir_tab.size(); r++)
        begin
            if (dir_tab[r].csi)
            begin
                feed(acsi_pkg::CH_ESC);
                feed(acsi_pkg::CH_LBR);
            end
            for (k = 0; k < dir_tab[r].body.len(); k++)
                feed(dir_tab[r].body[k]);
            feed(dir_tab[r].last, dir_tab[r].pinned, dir_tab[r].want);
        end

        counted = 0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            hold_until_empty();
            case (ph)
                0: begin rows_next = 8'd255; cols_next = 8'd255; end
                1: begin rows_next = 8'd1;   cols_next = 8'd1;   end
                2: begin rows_next = 8'd0;   cols_next = 8'd0;   end
                4: begin rows_next = 8'd200; cols_next = 8'd3;   end
                default:
                begin
                    rows_next = 8'($urandom_range(2, 60));
                    cols_next = 8'($urandom_range(2, 160));
                end
            endcase
            set_size(rows_next, cols_next);
            while (counted < (ph + 1) * PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    build_csi(1'b0);
                else if (pick < 79)
                    build_csi(1'b1);
                else if (pick < 86)
                begin
                    seq_bytes.delete();
                    seq_bytes.push_back(acsi_pkg::CH_ESC);
                    seq_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    // plain traffic, mostly ignored by the parser
                    seq_bytes.delete();
                    repeat ($urandom_range(1, 3)) seq_bytes.push_back(8'($urandom_range(0, 255)));
                end
                counted += seq_bytes.size();
                for (k = 0; k < seq_bytes.size(); k++)
                    feed(seq_bytes[k]);
                if ($urandom_range(0, 59) == 0)
                    hold_until_empty();
            end
        end

        hold_until_empty();
        if (miss_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
